// ----- rtl/dip_pkg.sv -----
// ----------------------------------------------------------------------------
// dip_pkg: shared types and constants of the decimal string parser
// character codes, error codes, register indexes, suffix shifts, beat and config structs
// ----------------------------------------------------------------------------
package dip_pkg;

    // default result width
    localparam int VALUE_BITS_DEF = 64;

    // width of the max_value register
    localparam int MAX_W = 64;

    // configuration register indexes
    localparam logic CFG_MAX_VALUE   = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    // result error codes
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_CONV    = 2'd1;
    localparam logic [1:0] ERR_RANGE   = 2'd2;
    localparam logic [1:0] ERR_BAD_MAX = 2'd3;

    // ascii codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_K_UP  = 8'h4b;
    localparam logic [7:0] CH_K_LO  = 8'h6b;
    localparam logic [7:0] CH_M_UP  = 8'h4d;
    localparam logic [7:0] CH_M_LO  = 8'h6d;
    localparam logic [7:0] CH_G_UP  = 8'h47;
    localparam logic [7:0] CH_G_LO  = 8'h67;

    // suffix shift amounts (x1024, x1024^2, x1024^3)
    localparam int SUFFIX_MAX_SH = 30;
    localparam logic [4:0] SH_NONE = 5'd0;
    localparam logic [4:0] SH_K    = 5'd10;
    localparam logic [4:0] SH_M    = 5'd20;
    localparam logic [4:0] SH_G    = 5'd30;

    // one input beat as held in the input register
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       is_last;
    } t_in_beat;

    // configuration seen by the parse core
    typedef struct packed {
        logic [MAX_W-1:0] max_value;
        logic [MAX_W:0]   max_plus1;
        logic             signed_mode;
    } t_cfg;

endpackage

// ----- rtl/decimal_integer_string_parser_top.sv -----
// ----------------------------------------------------------------------------
// decimal_integer_string_parser_top: ascii decimal string to integer
// streaming parser with K/M/G binary suffix, sign and range checks
// ----------------------------------------------------------------------------
// Usage:
//   slave stream carries one character per beat: tdata = ch, tuser = has_char,
//   tlast marks the final beat of a string. A beat with tuser low and tlast
//   high ends an empty string; tuser and tlast both low is a no-op beat.
//   master stream carries one result per string: tdata = value (two's
//   complement in signed mode, zero on error), tuser = error code.
//   cfg channel writes max_value (index 0) and signed_mode (index 1); it is
//   always ready and should only be used between strings.
// Timing:
//   one character per cycle, sustained, while no last beat waits on a
//   pending result. A beat is held in the input register, where the
//   single-pass step (multiply-by-ten shift-add, suffix shift, range
//   compare) updates the parse state; the result of a last beat is then
//   registered in the output register, whose valid flag drives tvalid.
// Reset and stall:
//   synchronous active-low reset empties both registers, clears the parse
//   state and restores max_value to all ones and unsigned mode. If the
//   receiver stalls, character beats keep flowing; only a last beat waits
//   in the input register until the pending result is taken.
// ----------------------------------------------------------------------------
module decimal_integer_string_parser_top #(
    parameter int VALUE_BITS = dip_pkg::VALUE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [7:0] ch
    input  logic [0:0]                  s_axis_tuser,   // [0] has_char
    input  logic                        s_axis_tlast,   // is_last
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [((VALUE_BITS+7)/8)*8-1:0] m_axis_tdata, // [VALUE_BITS-1:0] value
    output logic [1:0]                  m_axis_tuser,   // [1:0] error_code
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_addr,
    input  logic [dip_pkg::MAX_W-1:0]   i_cfg_data
);

    localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

    dip_pkg::t_cfg         cfg;
    dip_pkg::t_in_beat     r_in;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_value;
    logic [1:0]            r_out_err;

    logic                  out_free;
    logic                  step;
    logic [VALUE_BITS-1:0] core_value;
    logic [1:0]            core_err;

    dip_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // a held beat advances unless it carries a result with nowhere to go
    assign out_free      = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && (!r_in.is_last || out_free);
    assign s_axis_tready = !r_in_valid || step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.ch       <= s_axis_tdata;
            r_in.has_char <= s_axis_tuser[0];
            r_in.is_last  <= s_axis_tlast;
        end
    end

    dip_parse_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_beat  (r_in),
        .i_cfg   (cfg),
        .o_value (core_value),
        .o_err   (core_err)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in.is_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.is_last) begin
            r_out_value <= core_value;
            r_out_err   <= core_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_value);
    assign m_axis_tuser  = r_out_err;

    // a failed parse always reports zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != dip_pkg::ERR_OK) |-> (r_out_value == '0))
        else $error("nonzero value with error code");

    // character beats never wait on the result side
    a_no_char_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in.is_last) |-> (step && s_axis_tready))
        else $error("non-last beat stalled");

    // a result is only produced by a last beat stepping through
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(step && r_in.is_last))
        else $error("result appeared without a last beat");

endmodule

// ----- rtl/dip_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dip_cfg_regs: configuration registers
// holds max_value, its successor and the signed mode flag
// ----------------------------------------------------------------------------
module dip_cfg_regs (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_addr,
    input  logic [dip_pkg::MAX_W-1:0] i_cfg_data,
    output dip_pkg::t_cfg            o_cfg
);

    logic [dip_pkg::MAX_W-1:0] r_max_value;
    logic [dip_pkg::MAX_W:0]   r_max_plus1;
    logic                      r_signed_mode;

    assign o_cfg_ready = 1'b1;

    // max+1 kept precomputed so the end-of-string compare has no adder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value   <= '1;
            r_max_plus1   <= {1'b1, {dip_pkg::MAX_W{1'b0}}};
            r_signed_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                dip_pkg::CFG_MAX_VALUE: begin
                    r_max_value <= i_cfg_data;
                    r_max_plus1 <= {1'b0, i_cfg_data} + {{dip_pkg::MAX_W{1'b0}}, 1'b1};
                end
                dip_pkg::CFG_SIGNED_MODE: begin
                    r_signed_mode <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.max_value   = r_max_value;
    assign o_cfg.max_plus1   = r_max_plus1;
    assign o_cfg.signed_mode = r_signed_mode;

endmodule

// ----- rtl/dip_parse_core.sv -----
// ----------------------------------------------------------------------------
// dip_parse_core: parse state and one-character step
// updates accumulator, sign, phase and sticky error, and forms the result
// ----------------------------------------------------------------------------
module dip_parse_core #(
    parameter int VALUE_BITS = dip_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  dip_pkg::t_in_beat     i_beat,
    input  dip_pkg::t_cfg         i_cfg,
    output logic [VALUE_BITS-1:0] o_value,
    output logic [1:0]            o_err
);

    localparam int SH_W = VALUE_BITS + dip_pkg::SUFFIX_MAX_SH;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_SUFFIX = 2'd2;

    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_neg, n_neg;
    logic [1:0]            r_phase, n_phase;
    logic [1:0]            r_err, n_err;

    // after-character values
    logic [VALUE_BITS-1:0] a_acc;
    logic                  a_neg;
    logic [1:0]            a_phase;
    logic [1:0]            a_err;

    logic                  is_digit;
    logic [VALUE_BITS+3:0] mul10;
    logic [4:0]            shamt;
    logic [SH_W-1:0]       shifted;
    logic                  bad_max;
    logic                  use_neg;
    logic                  over;
    logic [dip_pkg::MAX_W:0] acc_ext;
    logic [1:0]            fin_err;

    always_comb begin
        is_digit = (i_beat.ch >= dip_pkg::CH_0) && (i_beat.ch <= dip_pkg::CH_9);
        // acc*10 + d as shift-add, exact overflow from the carry bits
        mul10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
              + {{VALUE_BITS{1'b0}}, i_beat.ch[3:0]};

        case (i_beat.ch)
            dip_pkg::CH_K_UP, dip_pkg::CH_K_LO: shamt = dip_pkg::SH_K;
            dip_pkg::CH_M_UP, dip_pkg::CH_M_LO: shamt = dip_pkg::SH_M;
            dip_pkg::CH_G_UP, dip_pkg::CH_G_LO: shamt = dip_pkg::SH_G;
            default:                            shamt = dip_pkg::SH_NONE;
        endcase
        shifted = {{dip_pkg::SUFFIX_MAX_SH{1'b0}}, r_acc} << shamt;

        a_acc   = r_acc;
        a_neg   = r_neg;
        a_phase = r_phase;
        a_err   = r_err;
        if (i_beat.has_char && (r_err == dip_pkg::ERR_OK)) begin
            if (r_phase[1]) begin
                a_err = dip_pkg::ERR_CONV;
            end else if (is_digit) begin
                if (|mul10[VALUE_BITS+3:VALUE_BITS]) begin
                    a_err = dip_pkg::ERR_RANGE;
                end else begin
                    a_acc   = mul10[VALUE_BITS-1:0];
                    a_phase = PH_DIGITS;
                end
            end else if (shamt != dip_pkg::SH_NONE) begin
                if (|shifted[SH_W-1:VALUE_BITS]) begin
                    a_err = dip_pkg::ERR_RANGE;
                end else begin
                    a_acc   = shifted[VALUE_BITS-1:0];
                    a_phase = PH_SUFFIX;
                end
            end else if ((r_phase == PH_FIRST) && i_cfg.signed_mode &&
                         ((i_beat.ch == dip_pkg::CH_PLUS) ||
                          (i_beat.ch == dip_pkg::CH_MINUS))) begin
                a_neg   = (i_beat.ch == dip_pkg::CH_MINUS);
                a_phase = PH_DIGITS;
            end else begin
                a_err = dip_pkg::ERR_CONV;
            end
        end

        // end-of-string checks
        bad_max = i_cfg.signed_mode && (|i_cfg.max_value[dip_pkg::MAX_W-1:VALUE_BITS-1]);
        use_neg = i_cfg.signed_mode && a_neg && (a_acc != '0);
        acc_ext = (dip_pkg::MAX_W+1)'(a_acc);
        over    = use_neg ? (acc_ext > i_cfg.max_plus1)
                          : (acc_ext > {1'b0, i_cfg.max_value});
        if (bad_max) begin
            fin_err = dip_pkg::ERR_BAD_MAX;
        end else if (a_err != dip_pkg::ERR_OK) begin
            fin_err = a_err;
        end else if (over) begin
            fin_err = dip_pkg::ERR_RANGE;
        end else begin
            fin_err = dip_pkg::ERR_OK;
        end
        o_err   = fin_err;
        o_value = (fin_err != dip_pkg::ERR_OK) ? '0 : (use_neg ? (~a_acc + 1'b1) : a_acc);

        // last beat starts a fresh string
        if (i_beat.is_last) begin
            n_acc   = '0;
            n_neg   = 1'b0;
            n_phase = PH_FIRST;
            n_err   = dip_pkg::ERR_OK;
        end else begin
            n_acc   = a_acc;
            n_neg   = a_neg;
            n_phase = a_phase;
            n_err   = a_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_phase <= PH_FIRST;
            r_err   <= dip_pkg::ERR_OK;
        end else if (i_step) begin
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end

    // a finished string leaves the parser cleared
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_beat.is_last) |=>
        (r_acc == '0 && !r_neg && r_phase == PH_FIRST && r_err == dip_pkg::ERR_OK))
        else $error("parse state not cleared after last beat");

    // first error sticks until the string ends
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_beat.is_last && r_err != dip_pkg::ERR_OK) |=> (r_err == $past(r_err)))
        else $error("sticky error changed mid-string");

    // accumulator only moves while no error is recorded
    a_acc_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_beat.is_last && r_err != dip_pkg::ERR_OK) |=> $stable(r_acc))
        else $error("accumulator moved after an error");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: decimal integer string parser
// drives number strings one character per beat, predicts each result from a
// copy of the parse state and register settings, and compares every result
// beat against the oldest predicted one; both streams idle at random
// ----------------------------------------------------------------------------
module testbench;

    localparam int VALUE_BITS = dip_pkg::VALUE_BITS_DEF;
    localparam logic [VALUE_BITS-1:0] VAL_MASK = '1;

    // no-accept stretch that ends the run, covers the long receiver hold
    localparam int WATCHDOG_LIMIT = 3000;
    // receiver hold-off used to fill the block
    localparam int HOLD_CYCLES    = 400;
    // settle time before a register write and at the end
    localparam int DRAIN_CYCLES   = 4;
    localparam int END_CYCLES     = 12;
    // random beats per register setting
    localparam int PHASE_BEATS    = 205;
    localparam int NUM_PHASES     = 8;

    // parse position, the last code is never entered
    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_DIGITS = 2'd1,
        PH_SUFFIX = 2'd2
    } t_phase;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata;   // [7:0] ch
    logic [0:0]                s_axis_tuser;   // [0] has_char
    logic                      s_axis_tlast;   // is_last
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [VALUE_BITS-1:0]     m_axis_tdata;   // [63:0] value
    logic [1:0]                m_axis_tuser;   // [1:0] error_code
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic                      i_cfg_addr;
    logic [dip_pkg::MAX_W-1:0] i_cfg_data;

    decimal_integer_string_parser_top #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // parse predictor and store of expected values
    // ------------------------------------------------------------------------
    class parse_scoreboard;
        logic [dip_pkg::MAX_W-1:0] max_value;
        logic                      signed_mode;
        logic [VALUE_BITS-1:0]     magnitude;
        logic                      negative;
        t_phase                    phase;
        logic [1:0]                sticky_code;
        logic [VALUE_BITS-1:0]     want_value[$];
        logic [1:0]                want_code[$];
        int unsigned               mismatches;
        int unsigned               results_seen;

        function new();
            max_value    = '1;
            signed_mode  = 1'b0;
            mismatches   = 0;
            results_seen = 0;
            clear_string();
        endfunction

        function void clear_string();
            magnitude   = '0;
            negative    = 1'b0;
            phase       = PH_START;
            sticky_code = dip_pkg::ERR_OK;
        endfunction

        function void write_reg(logic idx, logic [dip_pkg::MAX_W-1:0] data);
            if (idx == dip_pkg::CFG_MAX_VALUE) begin
                max_value = data;
            end else begin
                signed_mode = data[0];
            end
        endfunction

        function int pending();
            return want_code.size();
        endfunction

        function void take_char(logic [7:0] c);
            logic [VALUE_BITS-1:0] digit;
            logic [4:0]            sh;
            if (sticky_code != dip_pkg::ERR_OK) return;
            // anything after a suffix breaks the string
            if (phase != PH_START && phase != PH_DIGITS) begin
                sticky_code = dip_pkg::ERR_CONV;
                return;
            end
            if (c >= dip_pkg::CH_0 && c <= dip_pkg::CH_9) begin
                digit = VALUE_BITS'(c - dip_pkg::CH_0);
                // exact overflow of acc*10+digit
                if (magnitude > (VAL_MASK - digit) / 10) begin
                    sticky_code = dip_pkg::ERR_RANGE;
                end else begin
                    magnitude = magnitude * 10 + digit;
                    phase     = PH_DIGITS;
                end
                return;
            end
            case (c)
                dip_pkg::CH_K_UP, dip_pkg::CH_K_LO: sh = dip_pkg::SH_K;
                dip_pkg::CH_M_UP, dip_pkg::CH_M_LO: sh = dip_pkg::SH_M;
                dip_pkg::CH_G_UP, dip_pkg::CH_G_LO: sh = dip_pkg::SH_G;
                default:                            sh = dip_pkg::SH_NONE;
            endcase
            if (sh != dip_pkg::SH_NONE) begin
                if (magnitude > (VAL_MASK >> sh)) begin
                    sticky_code = dip_pkg::ERR_RANGE;
                end else begin
                    magnitude = magnitude << sh;
                    phase     = PH_SUFFIX;
                end
                return;
            end
            if (phase == PH_START && signed_mode &&
                (c == dip_pkg::CH_PLUS || c == dip_pkg::CH_MINUS)) begin
                negative = (c == dip_pkg::CH_MINUS);
                phase    = PH_DIGITS;
                return;
            end
            sticky_code = dip_pkg::ERR_CONV;
        endfunction

        function void note_beat(logic [7:0] c, logic has_char, logic is_last);
            logic [VALUE_BITS-1:0] value;
            logic [1:0]            code;
            if (has_char) take_char(c);
            if (!is_last) return;
            value = '0;
            code  = sticky_code;
            if (signed_mode) begin
                // invalid maximum outranks every other error
                if (max_value > (VAL_MASK >> 1)) begin
                    code = dip_pkg::ERR_BAD_MAX;
                end else if (code == dip_pkg::ERR_OK) begin
                    if (negative && magnitude != 0) begin
                        if ({1'b0, magnitude} > {1'b0, max_value} + 65'd1)
                            code = dip_pkg::ERR_RANGE;
                        else value = '0 - magnitude;
                    end else if (magnitude > max_value) begin
                        code = dip_pkg::ERR_RANGE;
                    end else begin
                        value = magnitude;
                    end
                end
            end else if (code == dip_pkg::ERR_OK) begin
                if (magnitude > max_value) code = dip_pkg::ERR_RANGE;
                else value = magnitude;
            end
            if (code != dip_pkg::ERR_OK) value = '0;
            want_value.push_back(value);
            want_code.push_back(code);
            clear_string();
        endfunction

        task report(string msg);
            if (mismatches < 100) $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_result(logic [VALUE_BITS-1:0] got_value, logic [1:0] got_code);
            logic [VALUE_BITS-1:0] exp_value;
            logic [1:0]            exp_code;
            results_seen++;
            if (want_code.size() == 0) begin
                report($sformatf("result %0d unexpected, value %0h code %0d",
                                 results_seen, got_value, got_code));
                return;
            end
            exp_value = want_value.pop_front();
            exp_code  = want_code.pop_front();
            if (got_code !== exp_code)
                report($sformatf("result %0d error code %0d, expected %0d",
                                 results_seen, got_code, exp_code));
            if (got_value !== exp_value)
                report($sformatf("result %0d value %0h, expected %0h",
                                 results_seen, got_value, exp_value));
        endtask
    endclass

    parse_scoreboard sb;

    // ------------------------------------------------------------------------
    // run control shared by the driving processes
    // ------------------------------------------------------------------------
    bit                 calm;          // no idling on either side
    bit                 hold_req;      // ask the receiver for one long hold-off
    int unsigned        tx_odds;       // sender gap 1 in tx_odds beats, 0 none
    int unsigned        rx_odds;       // receiver stall 1 in rx_odds runs, 0 none
    int unsigned        beats_sent;
    int unsigned        quiet_cycles;
    dip_pkg::t_in_beat  str_beats[$];  // string being assembled

    // ------------------------------------------------------------------------
    // result side: monitor and watchdog sample pre-edge values
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random ready bursts, one long hold on request
    initial begin
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                // block fills up, a last beat then stalls the input
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // tvalid stays high after a beat so strings run back to back
    task send_beat(dip_pkg::t_in_beat b);
        if (!calm && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b.ch;
        s_axis_tuser  <= b.has_char;
        s_axis_tlast  <= b.is_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(b.ch, b.has_char, b.is_last);
        beats_sent++;
    endtask

    // only called with nothing in flight
    task write_reg(logic idx, logic [dip_pkg::MAX_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    function void put_char(logic [7:0] c);
        dip_pkg::t_in_beat b;
        b.ch       = c;
        b.has_char = 1'b1;
        b.is_last  = 1'b0;
        str_beats.push_back(b);
    endfunction

    function void put_noop();
        dip_pkg::t_in_beat b;
        b.ch       = 8'($urandom_range(0, 255));
        b.has_char = 1'b0;
        b.is_last  = 1'b0;
        str_beats.push_back(b);
    endfunction

    function void put_text(string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endfunction

    function logic [7:0] pick_suffix(int unsigned which);
        case (which)
            0:       return dip_pkg::CH_K_UP;
            1:       return dip_pkg::CH_K_LO;
            2:       return dip_pkg::CH_M_UP;
            3:       return dip_pkg::CH_M_LO;
            4:       return dip_pkg::CH_G_UP;
            default: return dip_pkg::CH_G_LO;
        endcase
    endfunction

    // marks the end of the string, on its last character or as an empty beat
    task flush_string(bit empty_end);
        dip_pkg::t_in_beat b;
        if (empty_end || str_beats.size() == 0) begin
            b.ch       = 8'($urandom_range(0, 255));
            b.has_char = 1'b0;
            b.is_last  = 1'b1;
            str_beats.push_back(b);
        end else begin
            str_beats[str_beats.size() - 1].is_last = 1'b1;
        end
        foreach (str_beats[i]) send_beat(str_beats[i]);
        str_beats.delete();
    endtask

    // mostly well-formed numbers, aimed at the range edges, plus noise
    task random_string();
        int unsigned           kind;
        int unsigned           which;
        logic [VALUE_BITS-1:0] num;
        bit                    has_suffix;
        kind       = $urandom_range(0, 99);
        has_suffix = 1'b0;
        if (kind < 12) begin
            // noise: random bytes and no-op beats
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 4) == 0) put_noop();
                else put_char(8'($urandom_range(0, 255)));
            end
        end else begin
            // leading sign, mostly where it is legal
            if ((sb.signed_mode && $urandom_range(0, 1) == 0) || $urandom_range(0, 15) == 0)
                put_char($urandom_range(0, 1) ? dip_pkg::CH_MINUS : dip_pkg::CH_PLUS);
            which = $urandom_range(0, 99);
            if (which < 5) begin
                // no digits at all
            end else if (which < 55) begin
                if ($urandom_range(0, 7) == 0) put_char(dip_pkg::CH_0);
                num = VALUE_BITS'($urandom_range(0, 99999));
                put_text($sformatf("%0d", num));
            end else if (which < 85) begin
                case ($urandom_range(0, 5))
                    0: num = sb.max_value;
                    1: num = sb.max_value + 1;
                    2: num = VAL_MASK;
                    3: num = VAL_MASK >> 1;
                    4: num = {$urandom, $urandom};
                    default: begin
                        // largest value a suffix can take
                        which = $urandom_range(0, 5);
                        case (which / 2)
                            0:       num = VAL_MASK >> dip_pkg::SH_K;
                            1:       num = VAL_MASK >> dip_pkg::SH_M;
                            default: num = VAL_MASK >> dip_pkg::SH_G;
                        endcase
                        has_suffix = 1'b1;
                    end
                endcase
                case ($urandom_range(0, 2))
                    0: num = num - 1;
                    2: num = num + 1;
                    default: ;
                endcase
                put_text($sformatf("%0d", num));
                if (has_suffix) put_char(pick_suffix(which));
            end else begin
                repeat ($urandom_range(15, 22))
                    put_char(dip_pkg::CH_0 + 8'($urandom_range(0, 9)));
            end
            if (!has_suffix && $urandom_range(0, 3) == 0) begin
                put_char(pick_suffix($urandom_range(0, 5)));
                has_suffix = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) put_noop();
            // broken strings: stray byte, late sign or second suffix; an extra digit breaks only a suffixed one
            if (kind < 30) begin
                case ($urandom_range(0, 3))
                    0: put_char(8'($urandom_range(0, 255)));
                    1: put_char($urandom_range(0, 1) ? dip_pkg::CH_MINUS : dip_pkg::CH_PLUS);
                    2: put_char(dip_pkg::CH_0 + 8'($urandom_range(0, 9)));
                    default: put_char(pick_suffix($urandom_range(0, 5)));
                endcase
            end
        end
        flush_string($urandom_range(0, 3) == 0);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [dip_pkg::MAX_W-1:0] phase_max;
        logic                      phase_signed;
        int unsigned               phase_end;
        sb         = new();
        calm       = 1'b0;
        hold_req   = 1'b0;
        tx_odds    = 0;
        rx_odds    = 0;
        beats_sent = 0;
        quiet_cycles = 0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= dip_pkg::CFG_MAX_VALUE;
        i_cfg_data    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings, reset settings: unsigned, max all ones
        flush_string(1'b1);                 // empty string
        put_text("1G");      flush_string(1'b0);
        put_char(8'hff);     flush_string(1'b0);
        put_char(8'h00);     flush_string(1'b0);
        put_text("2k3");     flush_string(1'b0);  // character after suffix
        put_noop();
        put_text("m");       flush_string(1'b0);  // lone suffix
        put_text("-4");      flush_string(1'b0);  // sign in unsigned mode
        put_text("7x9");     flush_string(1'b1);  // chars after a bad one ignored
        write_reg(dip_pkg::CFG_MAX_VALUE, '0);
        put_text("0");       flush_string(1'b0);
        put_text("3");       flush_string(1'b0);  // above the limit
        write_reg(dip_pkg::CFG_SIGNED_MODE, dip_pkg::MAX_W'(1));
        put_text("-");       flush_string(1'b0);  // lone sign
        put_text("-1");      flush_string(1'b0);  // negative may reach max+1
        put_text("+1");      flush_string(1'b0);
        put_text("5-");      flush_string(1'b0);  // sign not first
        write_reg(dip_pkg::CFG_MAX_VALUE, '1);
        put_text("8");       flush_string(1'b0);  // invalid maximum

        // random strings under a series of settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin phase_max = '1;                 phase_signed = 1'b0; end
                1: begin phase_max = '0;                 phase_signed = 1'b0; end
                2: begin phase_max = dip_pkg::MAX_W'($urandom_range(0, 5000));
                         phase_signed = 1'b0; end
                3: begin phase_max = {$urandom, $urandom}; phase_signed = 1'b0; end
                4: begin phase_max = VAL_MASK >> 1;      phase_signed = 1'b1; end
                5: begin phase_max = '0;                 phase_signed = 1'b1; end
                6: begin phase_max = (VAL_MASK >> 1) + 1; phase_signed = 1'b1; end
                default: begin
                    phase_max    = {1'b0, $urandom, 31'($urandom)};
                    phase_signed = 1'b1;
                end
            endcase
            write_reg(dip_pkg::CFG_MAX_VALUE, phase_max);
            write_reg(dip_pkg::CFG_SIGNED_MODE, dip_pkg::MAX_W'(phase_signed));
            tx_odds = (p % 3 == 0) ? 0 : 3 + 2 * (p % 3);
            rx_odds = (p % 4 == 1) ? 0 : 2 + (p % 3);
            // last setting runs with both sides always ready
            calm = (p == NUM_PHASES - 1);
            if (p == 2) hold_req = 1'b1;
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) random_string();
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/dip_pkg.sv
rtl/dip_cfg_regs.sv
rtl/dip_parse_core.sv
rtl/decimal_integer_string_parser_top.sv
bench/testbench.sv
